### rtl/life_grid_generation_step_assert.svh
// Assertion macros shared by the grid step logic.
`ifndef LIFE_GRID_GENERATION_STEP_ASSERT_SVH
`define LIFE_GRID_GENERATION_STEP_ASSERT_SVH

// Condition must never hold.
`define LGS_ASSERT_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define LGS_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

### rtl/lgs_pkg.sv
package lgs_pkg;

   localparam int DEF_MAX_WIDTH  = 64;
   localparam int DEF_MAX_HEIGHT = 64;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int CFG_W      = 7;

   typedef logic [1:0] op_type;
   localparam op_type OP_WRITE = 2'd0;
   localparam op_type OP_READ  = 2'd1;
   localparam op_type OP_STEP  = 2'd2;

   typedef logic [5:0] coord_type;

   typedef logic reg_index_type;
   localparam reg_index_type REG_GRID_WIDTH  = 1'b0;
   localparam reg_index_type REG_GRID_HEIGHT = 1'b1;

   localparam logic [CFG_W-1:0] GRID_RESET = 7'd64;

   localparam logic [3:0] BIRTH_COUNT   = 4'd3;
   localparam logic [3:0] SURVIVE_COUNT = 4'd2;

   typedef struct packed {
      logic [CFG_W-1:0] grid_width;
      logic [CFG_W-1:0] grid_height;
   } cfg_type;

endpackage

### rtl/lgs_req_if.sv
interface lgs_req_if import lgs_pkg::*; ();
   logic      valid;
   logic      ready;
   op_type    operation;
   coord_type row;
   coord_type col;
   logic      cell_in;

   modport source (output valid, output operation, output row, output col, output cell_in,
                   input ready);
   modport sink (input valid, input operation, input row, input col, input cell_in,
                 output ready);
endinterface

### rtl/lgs_rsp_if.sv
interface lgs_rsp_if import lgs_pkg::*; ();
   logic   valid;
   logic   ready;
   logic   cell_out;
   op_type done_operation;

   modport source (output valid, output cell_out, output done_operation, input ready);
   modport sink (input valid, input cell_out, input done_operation, output ready);
endinterface

### rtl/lgs_csr.sv
module lgs_csr import lgs_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   logic [CFG_W-1:0] width_ff;
   logic [CFG_W-1:0] height_ff;
   reg_index_type    reg_idx;

   assign reg_idx = paddr[CSR_ADDR_W-1];
   assign pready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= GRID_RESET;
         height_ff <= GRID_RESET;
      end else if (psel && penable && pwrite) begin
         unique case (reg_idx)
            REG_GRID_WIDTH:  width_ff  <= pwdata[CFG_W-1:0];
            REG_GRID_HEIGHT: height_ff <= pwdata[CFG_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_GRID_WIDTH:  prdata = CSR_DATA_W'(width_ff);
         REG_GRID_HEIGHT: prdata = CSR_DATA_W'(height_ff);
         default:         prdata = '0;
      endcase
   end

   assign cfg.grid_width  = width_ff;
   assign cfg.grid_height = height_ff;

endmodule

### rtl/lgs_row_rule.sv
module lgs_row_rule import lgs_pkg::*; #(
   parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
   input  logic [MAX_WIDTH-1:0]            up_row,
   input  logic [MAX_WIDTH-1:0]            mid_row,
   input  logic [MAX_WIDTH-1:0]            down_row,
   input  logic [$clog2(MAX_WIDTH+1)-1:0]  width_ext,
   output logic [MAX_WIDTH-1:0]            next_row
);

   localparam int COL_W = $clog2(MAX_WIDTH);

   logic [COL_W-1:0] last_col;
   logic             up_last;
   logic             mid_last;
   logic             down_last;

   assign last_col  = COL_W'(width_ext - 1'b1);
   assign up_last   = up_row[last_col];
   assign mid_last  = mid_row[last_col];
   assign down_last = down_row[last_col];

   for (genvar c = 0; c < MAX_WIDTH; c++) begin : g_lane
      logic [2:0] left_bits;
      logic [2:0] right_bits;
      logic [3:0] count;
      logic       active;

      if (c == 0) begin : g_first
         assign left_bits = {up_last, mid_last, down_last};
      end else begin : g_inner
         assign left_bits = {up_row[c-1], mid_row[c-1], down_row[c-1]};
      end

      if (c == MAX_WIDTH - 1) begin : g_end
         assign right_bits = {up_row[0], mid_row[0], down_row[0]};
      end else begin : g_body
         assign right_bits = (last_col == COL_W'(c)) ?
                             {up_row[0], mid_row[0], down_row[0]} :
                             {up_row[c+1], mid_row[c+1], down_row[c+1]};
      end

      assign count = 4'(left_bits[2]) + 4'(left_bits[1]) + 4'(left_bits[0])
                   + 4'(right_bits[2]) + 4'(right_bits[1]) + 4'(right_bits[0])
                   + 4'(up_row[c]) + 4'(down_row[c]);
      assign active = (COL_W'(c) <= last_col);
      assign next_row[c] = active ?
                           ((count == BIRTH_COUNT) || (mid_row[c] && (count == SURVIVE_COUNT))) :
                           mid_row[c];
   end

endmodule

### rtl/life_grid_generation_step.sv
// Toroidal B3/S23 life grid of MAX_HEIGHT rows by MAX_WIDTH one-bit cells.
// req_ch carries one item per command: write a cell, read a cell, or advance
// the active region (grid_height rows by grid_width columns, set over the
// APB port) by one generation. Each command except the unused code 3 returns
// one item on rsp_ch with the read value (zero otherwise) and the echoed code.
// Cell write/read: result registered from ST_CELL, or from ST_FINISH while rsp_ch
// stalls; a new command is taken only once the block is back in ST_IDLE.
// Generation: the grid rows live in a row-wide memory; a copy pass moves H
// rows (H the active height) into a snapshot memory at one row per cycle, then
// a second pass streams the snapshot through a three-row window and writes one
// new row per cycle.
// Reset clears the registers to 64 by 64 and then sweeps the grid memory to
// all dead, one row per cycle over all MAX_HEIGHT rows; req_ch.ready stays low
// during the sweep.
// A stalled rsp_ch holds its result in the output register; the next item is
// still taken, and its result waits until the register frees.
`include "life_grid_generation_step_assert.svh"

module life_grid_generation_step import lgs_pkg::*; #(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
   input  logic                  clock,
   input  logic                  reset,
   lgs_req_if.sink               req_ch,
   lgs_rsp_if.source             rsp_ch,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int ROW_W  = $clog2(MAX_HEIGHT);
   localparam int WEXT_W = $clog2(MAX_WIDTH + 1);
   localparam int HEXT_W = $clog2(MAX_HEIGHT + 1);
   localparam int ISS_W  = $clog2(MAX_HEIGHT + 3);
   localparam logic [ROW_W-1:0] CLR_LAST = ROW_W'(MAX_HEIGHT - 1);

   typedef enum logic [2:0] {
      ST_CLEAR, ST_IDLE, ST_CELL, ST_COPY, ST_DRAIN, ST_GEN, ST_FINISH
   } state_type;

   cfg_type cfg;

   lgs_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   logic [WEXT_W-1:0] w_ext;
   logic [HEXT_W-1:0] h_ext;

   always_comb begin
      if (cfg.grid_width == '0) begin
         w_ext = WEXT_W'(1);
      end else if (32'(cfg.grid_width) > 32'(MAX_WIDTH)) begin
         w_ext = WEXT_W'(MAX_WIDTH);
      end else begin
         w_ext = WEXT_W'(cfg.grid_width);
      end
      if (cfg.grid_height == '0) begin
         h_ext = HEXT_W'(1);
      end else if (32'(cfg.grid_height) > 32'(MAX_HEIGHT)) begin
         h_ext = HEXT_W'(MAX_HEIGHT);
      end else begin
         h_ext = HEXT_W'(cfg.grid_height);
      end
   end

   state_type         state_ff;
   logic [ROW_W-1:0]  cnt_ff;
   logic [ROW_W-1:0]  rd_row_ff;
   logic [ROW_W-1:0]  wr_row_ff;
   logic [ISS_W-1:0]  iss_cnt_ff;
   logic [1:0]        fill_ff;
   logic              rvalid_ff;
   logic              wvalid_ff;
   logic              snap_we_ff;
   logic [ROW_W-1:0]  snap_wa_ff;
   logic              rsp_valid_ff;
   logic              rsp_cell_ff;
   op_type            rsp_op_ff;
   op_type            op_ff;
   coord_type         row_ff;
   coord_type         col_ff;
   logic              cell_in_ff;
   logic              inside_ff;
   logic              pend_cell_ff;
   logic [WEXT_W-1:0] gw_ff;
   logic [HEXT_W-1:0] gh_ff;

   logic [MAX_WIDTH-1:0] cell_mem [MAX_HEIGHT];
   logic [MAX_WIDTH-1:0] snap_mem [MAX_HEIGHT];
   logic [MAX_WIDTH-1:0] cell_rd_ff;
   logic [MAX_WIDTH-1:0] snap_rd_ff;
   logic [MAX_WIDTH-1:0] up_ff;
   logic [MAX_WIDTH-1:0] mid_ff;
   logic [MAX_WIDTH-1:0] down_ff;
   logic [MAX_WIDTH-1:0] next_row;

   logic                 req_fire;
   logic                 in_region;
   logic                 out_free;
   logic                 res_load;
   logic                 res_cell;
   logic                 cell_result;
   logic                 gen_issue;
   logic [ROW_W-1:0]     last_row;
   logic [ROW_W-1:0]     cell_ra;
   logic                 cell_we;
   logic [ROW_W-1:0]     cell_wa;
   logic [MAX_WIDTH-1:0] cell_wd;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign in_region    = (32'(req_ch.row) < 32'(h_ext)) && (32'(req_ch.col) < 32'(w_ext));
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign res_load     = ((state_ff == ST_CELL) || (state_ff == ST_FINISH)) && out_free;
   assign cell_result  = (op_ff == OP_READ) && inside_ff && cell_rd_ff[COL_W'(col_ff)];
   assign res_cell     = (state_ff == ST_CELL) ? cell_result : pend_cell_ff;
   assign last_row     = ROW_W'(gh_ff - 1'b1);
   assign gen_issue    = (state_ff == ST_GEN) &&
                         (iss_cnt_ff < (ISS_W'(gh_ff) + ISS_W'(2)));
   assign cell_ra      = (state_ff == ST_IDLE) ? ROW_W'(req_ch.row) : cnt_ff;

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.cell_out       = rsp_cell_ff;
   assign rsp_ch.done_operation = rsp_op_ff;

   lgs_row_rule #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_row_rule (
      .up_row    (up_ff),
      .mid_row   (mid_ff),
      .down_row  (down_ff),
      .width_ext (gw_ff),
      .next_row  (next_row)
   );

   always_comb begin
      cell_we = 1'b0;
      cell_wa = cnt_ff;
      cell_wd = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cell_we = 1'b1;
         end
         ST_CELL: begin
            cell_we = (op_ff == OP_WRITE) && inside_ff;
            cell_wa = ROW_W'(row_ff);
            cell_wd = cell_rd_ff;
            cell_wd[COL_W'(col_ff)] = cell_in_ff;
         end
         ST_GEN: begin
            cell_we = wvalid_ff;
            cell_wa = wr_row_ff;
            cell_wd = next_row;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cell_we) begin
         cell_mem[cell_wa] <= cell_wd;
      end
      cell_rd_ff <= cell_mem[cell_ra];
   end

   always_ff @(posedge clock) begin
      if (snap_we_ff) begin
         snap_mem[snap_wa_ff] <= cell_rd_ff;
      end
      snap_rd_ff <= snap_mem[rd_row_ff];
      snap_wa_ff <= cnt_ff;
      if (rvalid_ff) begin
         up_ff   <= mid_ff;
         mid_ff  <= down_ff;
         down_ff <= snap_rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cnt_ff       <= '0;
         rd_row_ff    <= '0;
         wr_row_ff    <= '0;
         iss_cnt_ff   <= '0;
         fill_ff      <= '0;
         rvalid_ff    <= 1'b0;
         wvalid_ff    <= 1'b0;
         snap_we_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rvalid_ff  <= gen_issue;
         wvalid_ff  <= rvalid_ff && (fill_ff >= 2'd2);
         snap_we_ff <= (state_ff == ST_COPY);
         if (rsp_valid_ff && rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (res_load) begin
            rsp_valid_ff <= 1'b1;
            rsp_cell_ff  <= res_cell;
            rsp_op_ff    <= op_ff;
         end
         unique case (state_ff)
            ST_CLEAR: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == CLR_LAST) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (req_fire) begin
                  op_ff      <= req_ch.operation;
                  row_ff     <= req_ch.row;
                  col_ff     <= req_ch.col;
                  cell_in_ff <= req_ch.cell_in;
                  inside_ff  <= in_region;
                  gw_ff      <= w_ext;
                  gh_ff      <= h_ext;
                  unique case (req_ch.operation) inside
                     OP_WRITE, OP_READ: state_ff <= ST_CELL;
                     OP_STEP: begin
                        cnt_ff   <= '0;
                        state_ff <= ST_COPY;
                     end
                     default: ;
                  endcase
               end
            end
            ST_CELL: begin
               pend_cell_ff <= cell_result;
               state_ff     <= out_free ? ST_IDLE : ST_FINISH;
            end
            ST_COPY: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == last_row) begin
                  state_ff <= ST_DRAIN;
               end
            end
            ST_DRAIN: begin
               rd_row_ff  <= last_row;
               iss_cnt_ff <= '0;
               wr_row_ff  <= '0;
               fill_ff    <= '0;
               state_ff   <= ST_GEN;
            end
            ST_GEN: begin
               if (gen_issue) begin
                  rd_row_ff  <= (rd_row_ff == last_row) ? '0 : rd_row_ff + 1'b1;
                  iss_cnt_ff <= iss_cnt_ff + 1'b1;
               end
               if (rvalid_ff && (fill_ff != 2'd3)) begin
                  fill_ff <= fill_ff + 1'b1;
               end
               if (wvalid_ff) begin
                  wr_row_ff <= wr_row_ff + 1'b1;
                  if (wr_row_ff == last_row) begin
                     pend_cell_ff <= 1'b0;
                     state_ff     <= ST_FINISH;
                  end
               end
            end
            ST_FINISH: begin
               if (out_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   `LGS_ASSERT_NEVER(a_snap_rw_overlap, snap_we_ff && (state_ff == ST_GEN), "snapshot copy still writing during generation")
   `LGS_ASSERT_IMPLY(a_gen_row_range, wvalid_ff, 32'(wr_row_ff) < 32'(gh_ff), "generation row write outside active height")
   `LGS_ASSERT_IMPLY(a_gen_end_drained, (state_ff == ST_GEN) && wvalid_ff && (wr_row_ff == last_row), !gen_issue && !rvalid_ff, "generation ended with snapshot reads in flight")
   `LGS_ASSERT_IMPLY(a_rsp_source, $rose(rsp_valid_ff), $past(state_ff == ST_CELL) || $past(state_ff == ST_FINISH), "result raised outside a finishing state")

endmodule
